@@ rtl/core/bds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants of the 2x2 RGBA8 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  // default largest source width (pixels)
  localparam int MAX_WIDTH_DEF = 4096;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SRC_W_BITS = 13;
  localparam int SRC_H_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;

  // one channel of a horizontal pair sum, and four of them
  localparam int PSUM_W = 10;
  typedef logic [3:0][PSUM_W-1:0] chan_sums_t;

  // what the back end does with a queued entry
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,  // even row: store pair sums in the line store
    OP_READ   = 2'd1,  // odd row: add stored sums and emit
    OP_DIRECT = 2'd2   // single-row image: sums already final, emit
  } op_t;

  typedef struct packed {
    op_t  op;
    logic eor;
    logic eof;
  } ctrl_t;

endpackage

@@ rtl/core/bds_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_front
// Configuration registers, raster counters and horizontal pairing. Builds
// one queue entry per completed pixel pair that survives cropping.
// ----------------------------------------------------------------------------
module bds_front #(
  parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF,
  parameter int AW        = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_alpha,
  input  logic                           q_full,
  output logic                           push,
  output bds_pkg::ctrl_t                 push_ctrl,
  output logic [AW-1:0]                  push_idx,
  output bds_pkg::chan_sums_t            push_sums
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW + 1 > bds_pkg::SRC_W_BITS) ? CW + 1 : bds_pkg::SRC_W_BITS;
  localparam int HW = bds_pkg::SRC_H_BITS;

  logic [bds_pkg::SRC_W_BITS-1:0] width_r, width_nxt;
  logic [HW-1:0]                  height_r, height_nxt;
  logic [CW-1:0]                  col_r, col_nxt;
  logic [HW-1:0]                  row_r, row_nxt;
  logic [31:0]                    left_r, left_nxt;

  logic           accept;
  logic           cfg_hit;
  logic [EW-1:0]  w_raw, w_eff, w_half, ow, x_e, ox_e;
  logic [HW-1:0]  h_eff, h_half, oh, oy;
  logic           w_one, h_one, x_in, y_in, have_pair;
  logic [31:0]    pix;
  bds_pkg::chan_sums_t pair;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;
  assign pix      = {in_alpha, in_blue, in_green, in_red};

  // effective image size and output size
  always_comb begin
    w_raw = EW'(width_r);
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff  = (height_r == '0) ? HW'(1) : height_r;
    w_one  = (w_eff == EW'(1));
    h_one  = (h_eff == HW'(1));
    w_half = w_eff >> 1;
    h_half = h_eff >> 1;
    ow     = (w_half > EW'(1)) ? w_half : EW'(1);
    oh     = (h_half > HW'(1)) ? h_half : HW'(1);
  end

  // position classification: dropped odd column or row, pair completion
  always_comb begin
    x_e       = EW'(col_r);
    ox_e      = x_e >> 1;
    oy        = h_one ? '0 : (row_r >> 1);
    x_in      = x_e < {w_eff[EW-1:1], 1'b0};
    y_in      = row_r < {h_eff[HW-1:1], 1'b0};
    have_pair = w_one || (x_in && col_r[0]);
  end

  // horizontal pair sums per channel
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (w_one) begin
        pair[c] = {1'b0, pix[8*c +: 8], 1'b0};
      end else begin
        pair[c] = bds_pkg::PSUM_W'(left_r[8*c +: 8]) + bds_pkg::PSUM_W'(pix[8*c +: 8]);
      end
    end
  end

  // queue entry
  always_comb begin
    push           = accept && have_pair && (h_one || y_in);
    push_idx       = AW'(col_r >> 1);
    push_ctrl.eor  = (ox_e == ow - EW'(1));
    push_ctrl.eof  = (ox_e == ow - EW'(1)) && (oy == oh - HW'(1));
    if (h_one) begin
      push_ctrl.op = bds_pkg::OP_DIRECT;
    end else if (row_r[0]) begin
      push_ctrl.op = bds_pkg::OP_READ;
    end else begin
      push_ctrl.op = bds_pkg::OP_WRITE;
    end
    for (int c = 0; c < 4; c++) begin
      push_sums[c] = h_one ? (pair[c] << 1) : pair[c];
    end
  end

  // config writes and raster counters
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    left_nxt   = left_r;
    cfg_hit    = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        bds_pkg::CFG_SRC_WIDTH: begin
          width_nxt = cfg_data[bds_pkg::SRC_W_BITS-1:0];
          cfg_hit   = 1'b1;
        end
        bds_pkg::CFG_SRC_HEIGHT: begin
          height_nxt = cfg_data[HW-1:0];
          cfg_hit    = 1'b1;
        end
        default: ;
      endcase
    end
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (!w_one && x_in && !col_r[0]) begin
        left_nxt = pix;
      end
      if (x_e == w_eff - EW'(1)) begin
        col_nxt = '0;
        row_nxt = (row_r == h_eff - HW'(1)) ? '0 : row_r + HW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bds_pkg::SRC_W_BITS'(1);
      height_r <= HW'(1);
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

@@ rtl/core/bds_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module bds_queue #(
  parameter int W     = 8,
  parameter int DEPTH = bds_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         not_empty,
  output logic         full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == NW'(DEPTH));
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/bds_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_back
// Line store access, vertical add, rounding and the output register.
// ----------------------------------------------------------------------------
module bds_back #(
  parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF,
  parameter int AW        = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bds_pkg::ctrl_t      q_ctrl,
  input  logic [AW-1:0]       q_idx,
  input  bds_pkg::chan_sums_t q_sums,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_alpha,
  output logic                out_end_of_row,
  output logic                out_end_of_frame
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SW = bds_pkg::PSUM_W + 1;

  bds_pkg::chan_sums_t line_mem [LINE_DEPTH];
  bds_pkg::chan_sums_t rd_r;

  logic                s1_v_r, s1_v_nxt;
  bds_pkg::ctrl_t      s1_ctrl_r;
  bds_pkg::chan_sums_t s1_sums_r;

  logic                out_v_r, out_v_nxt;
  logic [3:0][7:0]     out_pix_r, out_pix_nxt;
  logic                eor_r, eof_r;

  logic out_free, s1_adv, s1_free, is_write, s1_load;
  logic [SW-1:0] total;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign s1_free  = !s1_v_r || s1_adv;
  assign is_write = (q_ctrl.op == bds_pkg::OP_WRITE);
  assign pop      = q_valid && (is_write || s1_free);
  assign s1_load  = pop && !is_write;

  // line store: write on even rows, registered read on odd rows
  always_ff @(posedge clk) begin
    if (pop && is_write) begin
      line_mem[q_idx] <= q_sums;
    end
    if (pop && (q_ctrl.op == bds_pkg::OP_READ)) begin
      rd_r <= line_mem[q_idx];
    end
  end

  // stage 1 holds the entry while its line data is read
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctrl_r <= q_ctrl;
      s1_sums_r <= q_sums;
    end
  end

  // vertical add and rounded mean
  always_comb begin
    total = '0;
    for (int c = 0; c < 4; c++) begin
      if (s1_ctrl_r.op == bds_pkg::OP_READ) begin
        total = SW'(rd_r[c]) + SW'(s1_sums_r[c]) + SW'(2);
      end else begin
        total = SW'(s1_sums_r[c]) + SW'(2);
      end
      out_pix_nxt[c] = total[9:2];
    end
  end

  // output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r <= out_pix_nxt;
      eor_r     <= s1_ctrl_r.eor;
      eof_r     <= s1_ctrl_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_red          = out_pix_r[0];
  assign out_green        = out_pix_r[1];
  assign out_blue         = out_pix_r[2];
  assign out_alpha        = out_pix_r[3];
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;

endmodule

@@ rtl/core/box_downsample_2x2_rgba8_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_2x2_rgba8_core
// 2x2 box-filter downsampler for an RGBA8 raster stream.
// ----------------------------------------------------------------------------
// Source pixels enter on the in_ channel in raster order, one per transfer.
// Each completed 2x2 block gives one result on the out_ channel with the
// rounded mean of each channel; out_end_of_row and out_end_of_frame mark the
// last pixel of an output row and of the output image.
// src_width (index 0) and src_height (index 1) are set on the cfg_ channel
// between frames; a write restarts the raster position. cfg_ready is always
// high.
// Pixels are taken one per cycle while the queue is not full. A result passes
// from the queue through the line store read stage (stage 1) into the output
// register.
// Even source rows leave their horizontal pair sums in a line store of
// MAX_WIDTH/2 entries with one write or one read port access per cycle.
// Reset returns the size to 1x1, clears the raster position and empties the
// queue and output register. A stall on out_ holds the result; the four-entry
// queue keeps taking pixels until full, then in_stall rises.
// ----------------------------------------------------------------------------
module box_downsample_2x2_rgba8_core #(
  parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_alpha,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_end_of_row,
  output logic                           out_end_of_frame
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int QW = $bits(bds_pkg::ctrl_t) + AW + $bits(bds_pkg::chan_sums_t);

  logic                push, pop, q_full, q_valid;
  bds_pkg::ctrl_t      push_ctrl, q_ctrl;
  logic [AW-1:0]       push_idx, q_idx;
  bds_pkg::chan_sums_t push_sums, q_sums;
  logic [QW-1:0]       q_head;

  assign cfg_ready = 1'b1;

  // front end: counters, cropping and horizontal pairing
  bds_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .q_full    (q_full),
    .push      (push),
    .push_ctrl (push_ctrl),
    .push_idx  (push_idx),
    .push_sums (push_sums)
  );

  // decoupling queue
  bds_queue #(
    .W     (QW),
    .DEPTH (bds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctrl, push_idx, push_sums}),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign {q_ctrl, q_idx, q_sums} = q_head;

  // back end: line store, vertical add, output register
  bds_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ctrl           (q_ctrl),
    .q_idx            (q_idx),
    .q_sums           (q_sums),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

@@ rtl/core/bds_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_checker
// Port-level checks for the 2x2 downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module bds_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       out_end_of_row,
  input logic       out_end_of_frame
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha) && $stable(out_end_of_row)
      && $stable(out_end_of_frame))
    else $error("stalled result changed");

  // the last pixel of the image also closes its row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_row)
    else $error("end of frame without end of row");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // reset empties the queue, so input is taken straight away
  assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind box_downsample_2x2_rgba8_core bds_checker u_bds_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_red          (out_red),
  .out_green        (out_green),
  .out_blue         (out_blue),
  .out_alpha        (out_alpha),
  .out_end_of_row   (out_end_of_row),
  .out_end_of_frame (out_end_of_frame)
);
